>>> rtl/cic_pkg.sv
// cic_pkg: shared types and constants for the custom ISA CPU core.
// No dependencies.
package cic_pkg;

  localparam int unsigned INSN_BYTES = 5;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EXEC  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [7:0] {
    OP_ADD = 8'd0, OP_ADDW = 8'd1, OP_ADDI = 8'd2, OP_ADDIW = 8'd3,
    OP_JMP = 8'd4, OP_JMPI = 8'd5, OP_JEQ = 8'd6, OP_JEQI = 8'd7,
    OP_JNE = 8'd8, OP_JNEI = 8'd9, OP_JLT = 8'd10, OP_JLTI = 8'd11,
    OP_JGT = 8'd12, OP_JGTI = 8'd13, OP_PUSH = 8'd14, OP_PUSHW = 8'd15,
    OP_POP = 8'd16, OP_POPW = 8'd17, OP_MOV = 8'd18, OP_MOVW = 8'd19,
    OP_LDI = 8'd20, OP_LDIW = 8'd21, OP_LDFA = 8'd22, OP_LDFAW = 8'd23,
    OP_LDFAI = 8'd24, OP_LDFAIW = 8'd25, OP_STA = 8'd26, OP_STAW = 8'd27,
    OP_STAI = 8'd28, OP_STAIW = 8'd29, OP_CMP = 8'd30, OP_CMPW = 8'd31,
    OP_CMPI = 8'd32, OP_CMPIW = 8'd33, OP_HLT = 8'd34, OP_AND = 8'd35,
    OP_ANDW = 8'd36, OP_ANDI = 8'd37, OP_ANDIW = 8'd38, OP_OR = 8'd39,
    OP_ORW = 8'd40, OP_ORI = 8'd41, OP_ORIW = 8'd42, OP_INV = 8'd43,
    OP_INVW = 8'd44, OP_XOR = 8'd45, OP_XORW = 8'd46, OP_XORI = 8'd47,
    OP_XORIW = 8'd48, OP_REGADD = 8'd49, OP_REGADDW = 8'd50, OP_INY = 8'd51,
    OP_INX = 8'd52
  } op_t;

  // memory address source chosen by the controller
  typedef enum logic [2:0] {
    AS_HOST  = 3'd0,  // host address
    AS_FETCH = 3'd1,  // ip + fetch count
    AS_EA    = 3'd2,  // effective address
    AS_EA1   = 3'd3,  // effective address + 1
    AS_SP    = 3'd4,  // stack pointer
    AS_SPM1  = 3'd5,  // stack pointer - 1
    AS_SPP1  = 3'd6,  // stack pointer + 1
    AS_SPP2  = 3'd7   // stack pointer + 2
  } asel_t;

  // write data source
  typedef enum logic [1:0] {
    WD_HOST = 2'd0,
    WD_HI   = 2'd1,
    WD_LO   = 2'd2
  } wsel_t;

  // controller -> datapath
  typedef struct packed {
    logic       mem_en;
    logic       mem_we;
    asel_t      asel;
    wsel_t      wsel;
    logic       latch_cmd;  // capture host transaction
    logic [2:0] fbyte;      // fetch byte index being requested
    logic       fetch_cap;  // capture read data into fetch byte
    logic       decode;     // compute operands, latch ea / store value
    logic       cap_hi;     // capture read data as high data byte
    logic       cap_lo;     // capture read data as low data byte
    logic       exec;       // commit architectural update
    logic       result;     // load result register
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic  is_exec;
    logic  is_write;
    logic  is_read;
    logic  fault;
    logic  nrd;       // instruction reads data memory
    logic  rd_two;
    logic  nwr;
    logic  wr_two;
    logic  rd_stack;  // read uses stack addressing
    logic  wr_stack;
  } sts_t;

endpackage

>>> rtl/cic_ram.sv
// cic_ram: generic single-port RAM with registered read.
// No dependencies.
module cic_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
    end
  end
endmodule

>>> rtl/cic_datapath.sv
// cic_datapath: register file, operand decode, ALU and memory port.
// Depends on cic_pkg and cic_ram.
module cic_datapath #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cic_pkg::ctl_t     ctl,
  output cic_pkg::sts_t     sts,
  input  logic [1:0]        in_opcode,
  input  logic [15:0]       in_address,
  input  logic [7:0]        in_write_byte,
  output logic [7:0]        res_read_byte,
  output logic              res_running,
  output logic              res_fault,
  output logic [15:0]       res_pc,
  output logic [2:0]        res_flags
);
  import cic_pkg::*;

  logic [1:0]  cmd_r;
  logic [15:0] haddr_r;
  logic [7:0]  hbyte_r;
  logic [15:0] ra_r, rb_r, rc_r, rd_r, sp_r, ip_r;
  logic [7:0]  ix_r, iy_r;
  logic [2:0]  fl_r;
  logic [7:0]  op_r;
  logic [15:0] a0_r, a1_r;
  logic [15:0] ea_r, sv_r;
  logic [7:0]  dhi_r, dlo_r;
  logic [2:0]  fidx_r;     // index of the fetch byte in flight
  logic [7:0]  rdata;
  logic [ADDR_BITS-1:0] maddr;
  logic [15:0] addr16;
  logic [7:0]  wdata;

  cic_ram #(.WIDTH(8), .DEPTH(1 << ADDR_BITS)) u_ram (
    .clk(clk), .en(ctl.mem_en), .we(ctl.mem_we), .addr(maddr),
    .wdata(wdata), .rdata(rdata)
  );

  // register read helpers
  function automatic logic [7:0] g8(input logic [15:0] i, input logic [15:0] a,
      input logic [15:0] b, input logic [15:0] c, input logic [15:0] d,
      input logic [7:0] x, input logic [7:0] y);
    logic [7:0] v;
    case (i)
      16'd0: v = a[7:0];   16'd1: v = a[15:8];
      16'd2: v = b[7:0];   16'd3: v = b[15:8];
      16'd4: v = c[7:0];   16'd5: v = c[15:8];
      16'd6: v = d[7:0];   16'd7: v = d[15:8];
      16'd8: v = x;        16'd9: v = y;
      default: v = '0;
    endcase
    return v;
  endfunction

  logic [15:0] g16_a0, g16_a1;
  logic [7:0]  g8_a0, g8_a1, b1;
  logic        ok8_0, ok8_1, ok16_0, ok16_1;
  logic        z, l;

  always_comb begin
    unique case (a0_r)
      16'd0: g16_a0 = ra_r; 16'd1: g16_a0 = rb_r; 16'd2: g16_a0 = rc_r;
      16'd3: g16_a0 = rd_r; 16'd4: g16_a0 = sp_r; 16'd5: g16_a0 = ip_r;
      default: g16_a0 = '0;
    endcase
    unique case (a1_r)
      16'd0: g16_a1 = ra_r; 16'd1: g16_a1 = rb_r; 16'd2: g16_a1 = rc_r;
      16'd3: g16_a1 = rd_r; 16'd4: g16_a1 = sp_r; 16'd5: g16_a1 = ip_r;
      default: g16_a1 = '0;
    endcase
  end

  assign g8_a0  = g8(a0_r, ra_r, rb_r, rc_r, rd_r, ix_r, iy_r);
  assign g8_a1  = g8(a1_r, ra_r, rb_r, rc_r, rd_r, ix_r, iy_r);
  assign b1     = a1_r[7:0];
  assign ok8_0  = a0_r < 16'd10;
  assign ok8_1  = a1_r < 16'd10;
  assign ok16_0 = a0_r < 16'd6;
  assign ok16_1 = a1_r < 16'd6;
  assign z      = fl_r[1];
  assign l      = fl_r[2];

  // fault check and memory traffic class
  logic ok;
  always_comb begin
    ok = 1'b1;
    sts.nrd = 1'b0; sts.rd_two = 1'b0; sts.nwr = 1'b0; sts.wr_two = 1'b0;
    sts.rd_stack = 1'b0; sts.wr_stack = 1'b0;
    case (op_r)
      OP_ADD, OP_MOV, OP_CMP, OP_AND, OP_OR, OP_XOR: ok = ok8_0 && ok8_1;
      OP_ADDW, OP_MOVW, OP_LDFAW, OP_STAW, OP_CMPW, OP_ANDW, OP_ORW, OP_XORW:
        ok = ok16_0 && ok16_1;
      OP_ADDI, OP_PUSH, OP_POP, OP_LDI, OP_LDFAI, OP_CMPI, OP_ANDI, OP_ORI,
      OP_INV, OP_XORI, OP_REGADD: ok = ok8_0;
      OP_ADDIW, OP_JMP, OP_PUSHW, OP_POPW, OP_LDIW, OP_LDFAIW, OP_STAI, OP_STAIW,
      OP_CMPIW, OP_ANDIW, OP_ORIW, OP_INVW, OP_XORIW, OP_REGADDW: ok = ok16_0;
      OP_JEQ: ok = !z || ok16_0;
      OP_JNE: ok = z || ok16_0;
      OP_JLT: ok = !l || ok16_0;
      OP_JGT: ok = l || ok16_0;
      OP_LDFA: ok = ok8_0 && ok16_1;
      OP_STA: ok = ok16_0 && ok8_1;
      default: ok = 1'b1;
    endcase
    case (op_r)
      OP_POP:  begin sts.nrd = 1'b1; sts.rd_stack = 1'b1; end
      OP_POPW: begin sts.nrd = 1'b1; sts.rd_two = 1'b1; sts.rd_stack = 1'b1; end
      OP_LDFA, OP_LDFAI: sts.nrd = 1'b1;
      OP_LDFAW, OP_LDFAIW: begin sts.nrd = 1'b1; sts.rd_two = 1'b1; end
      OP_PUSH:  begin sts.nwr = 1'b1; sts.wr_stack = 1'b1; end
      OP_PUSHW: begin sts.nwr = 1'b1; sts.wr_two = 1'b1; sts.wr_stack = 1'b1; end
      OP_STA, OP_STAI: sts.nwr = 1'b1;
      OP_STAW, OP_STAIW: begin sts.nwr = 1'b1; sts.wr_two = 1'b1; end
      default: ;
    endcase
    sts.fault    = !ok;
    sts.is_exec  = cmd_r == CMD_EXEC;
    sts.is_write = cmd_r == CMD_WRITE;
    sts.is_read  = cmd_r == CMD_READ;
  end

  // memory address and write data
  always_comb begin
    unique case (ctl.asel)
      AS_HOST:  addr16 = haddr_r;
      AS_FETCH: addr16 = ip_r + {13'd0, ctl.fbyte};
      AS_EA:    addr16 = ea_r;
      AS_EA1:   addr16 = ea_r + 16'd1;
      AS_SP:    addr16 = sp_r;
      AS_SPM1:  addr16 = sp_r - 16'd1;
      AS_SPP1:  addr16 = sp_r + 16'd1;
      AS_SPP2:  addr16 = sp_r + 16'd2;
      default:  addr16 = haddr_r;
    endcase
    maddr = addr16[ADDR_BITS-1:0];
    case (ctl.wsel)
      WD_HI:   wdata = sv_r[15:8];
      WD_LO:   wdata = sv_r[7:0];
      default: wdata = hbyte_r;
    endcase
  end

  // effective address and store value, latched at decode
  logic [15:0] ea_nxt, sv_nxt;
  always_comb begin
    ea_nxt = g16_a0;
    sv_nxt = a1_r;
    case (op_r)
      OP_LDFA, OP_LDFAW: ea_nxt = g16_a1;
      OP_LDFAI, OP_LDFAIW: ea_nxt = a1_r;
      default: ea_nxt = g16_a0;
    endcase
    case (op_r)
      OP_PUSH:  sv_nxt = {8'd0, g8_a0};
      OP_PUSHW: sv_nxt = g16_a0;
      OP_STA:   sv_nxt = {8'd0, g8_a1};
      OP_STAW:  sv_nxt = g16_a1;
      OP_STAI:  sv_nxt = {8'd0, b1};
      default:  sv_nxt = a1_r;
    endcase
  end

  // execute: next architectural state
  logic [15:0] ra_n, rb_n, rc_n, rd_n, sp_n, ip_n;
  logic [7:0]  ix_n, iy_n;
  logic [2:0]  fl_n;
  logic        jump, run;
  logic [16:0] sum;
  logic [15:0] av;
  logic        wa;       // write to A with zero flag
  logic        w8, w16;
  logic [15:0] wv;
  logic [15:0] wi;
  logic [15:0] ldw;

  always_comb begin
    ra_n = ra_r; rb_n = rb_r; rc_n = rc_r; rd_n = rd_r;
    sp_n = sp_r; ip_n = ip_r; ix_n = ix_r; iy_n = iy_r; fl_n = fl_r;
    jump = 1'b0; run = 1'b1; wa = 1'b0; av = '0; sum = '0;
    w8 = 1'b0; w16 = 1'b0; wv = '0; wi = a0_r;
    ldw = {dhi_r, dlo_r};
    case (op_r)
      OP_ADD: begin
        sum = {9'd0, g8_a0} + {9'd0, g8_a1} + {16'd0, fl_r[0]};
        fl_n[0] = sum[8]; av = {8'd0, sum[7:0]}; wa = 1'b1;
      end
      OP_ADDI: begin
        sum = {9'd0, g8_a0} + {9'd0, b1} + {16'd0, fl_r[0]};
        fl_n[0] = sum[8]; av = {8'd0, sum[7:0]}; wa = 1'b1;
      end
      OP_ADDW: begin
        sum = {1'b0, g16_a0} + {1'b0, g16_a1} + {16'd0, fl_r[0]};
        fl_n[0] = sum[16]; av = sum[15:0]; wa = 1'b1;
      end
      OP_ADDIW: begin
        sum = {1'b0, g16_a0} + {1'b0, a1_r} + {16'd0, fl_r[0]};
        fl_n[0] = sum[16]; av = sum[15:0]; wa = 1'b1;
      end
      OP_JMP:  begin ip_n = g16_a0; jump = 1'b1; end
      OP_JMPI: begin ip_n = a0_r; jump = 1'b1; end
      OP_JEQ, OP_JEQI: if (z) begin
        ip_n = (op_r == OP_JEQ) ? g16_a0 : a0_r; jump = 1'b1; fl_n[1] = 1'b0;
      end
      OP_JNE, OP_JNEI: if (!z) begin
        ip_n = (op_r == OP_JNE) ? g16_a0 : a0_r; jump = 1'b1;
      end
      OP_JLT, OP_JLTI: if (l) begin
        ip_n = (op_r == OP_JLT) ? g16_a0 : a0_r; jump = 1'b1; fl_n[2] = 1'b0;
      end
      OP_JGT, OP_JGTI: if (!l) begin
        ip_n = (op_r == OP_JGT) ? g16_a0 : a0_r; jump = 1'b1;
      end
      OP_PUSH:  sp_n = sp_r - 16'd1;
      OP_PUSHW: sp_n = sp_r - 16'd2;
      OP_POP:   begin sp_n = sp_r + 16'd1; w8 = 1'b1; wv = {8'd0, dlo_r}; end
      OP_POPW:  begin sp_n = sp_r + 16'd2; w16 = 1'b1; wv = ldw; end
      OP_MOV:   begin w8 = 1'b1; wv = {8'd0, g8_a1}; end
      OP_MOVW:  begin w16 = 1'b1; wv = g16_a1; end
      OP_LDI:   begin w8 = 1'b1; wv = {8'd0, b1}; end
      OP_LDIW:  begin w16 = 1'b1; wv = a1_r; end
      OP_LDFA, OP_LDFAI: begin w8 = 1'b1; wv = {8'd0, dlo_r}; end
      OP_LDFAW, OP_LDFAIW: begin w16 = 1'b1; wv = ldw; end
      OP_CMP: begin fl_n[1] = g8_a0 == g8_a1; fl_n[2] = g8_a0 < g8_a1; end
      OP_CMPW: begin fl_n[1] = g16_a0 == g16_a1; fl_n[2] = g16_a0 < g16_a1; end
      OP_CMPI: begin fl_n[1] = g8_a0 == b1; fl_n[2] = g8_a0 < b1; end
      OP_CMPIW: begin fl_n[1] = g16_a0 == a1_r; fl_n[2] = g16_a0 < a1_r; end
      OP_HLT: run = 1'b0;
      OP_AND:   begin av = {8'd0, g8_a0 & g8_a1}; wa = 1'b1; end
      OP_ANDW:  begin av = g16_a0 & g16_a1; wa = 1'b1; end
      OP_ANDI:  begin av = {8'd0, g8_a0 & b1}; wa = 1'b1; end
      OP_ANDIW: begin av = g16_a0 & a1_r; wa = 1'b1; end
      OP_OR:    begin av = {8'd0, g8_a0 | g8_a1}; wa = 1'b1; end
      OP_ORW:   begin av = g16_a0 | g16_a1; wa = 1'b1; end
      OP_ORI:   begin av = {8'd0, g8_a0 | b1}; wa = 1'b1; end
      OP_ORIW:  begin av = g16_a0 | a1_r; wa = 1'b1; end
      OP_INV:   begin av = {8'd0, ~g8_a0}; wa = 1'b1; end
      OP_INVW:  begin av = ~g16_a0; wa = 1'b1; end
      OP_XOR:   begin av = {8'd0, g8_a0 ^ g8_a1}; wa = 1'b1; end
      OP_XORW:  begin av = g16_a0 ^ g16_a1; wa = 1'b1; end
      OP_XORI:  begin av = {8'd0, g8_a0 ^ b1}; wa = 1'b1; end
      OP_XORIW: begin av = g16_a0 ^ a1_r; wa = 1'b1; end
      OP_REGADD:  begin w8 = 1'b1; wv = {8'd0, g8_a0 + b1}; end
      OP_REGADDW: begin w16 = 1'b1; wv = g16_a0 + a1_r; end
      OP_INY: iy_n = iy_r + 8'd1;
      OP_INX: ix_n = ix_r + 8'd1;
      default: ;
    endcase
    if (wa) begin
      ra_n = av; fl_n[1] = av == 16'd0;
    end
    if (w8) begin
      case (wi)
        16'd0: ra_n[7:0] = wv[7:0];  16'd1: ra_n[15:8] = wv[7:0];
        16'd2: rb_n[7:0] = wv[7:0];  16'd3: rb_n[15:8] = wv[7:0];
        16'd4: rc_n[7:0] = wv[7:0];  16'd5: rc_n[15:8] = wv[7:0];
        16'd6: rd_n[7:0] = wv[7:0];  16'd7: rd_n[15:8] = wv[7:0];
        16'd8: ix_n = wv[7:0];       16'd9: iy_n = wv[7:0];
        default: ;
      endcase
    end
    if (w16) begin
      case (wi)
        16'd0: ra_n = wv; 16'd1: rb_n = wv; 16'd2: rc_n = wv;
        16'd3: rd_n = wv; 16'd4: sp_n = wv; 16'd5: ip_n = wv;
        default: ;
      endcase
    end
    if (!jump) ip_n = ip_n + 16'(INSN_BYTES);
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_cmd) begin
      cmd_r <= in_opcode; haddr_r <= in_address; hbyte_r <= in_write_byte;
    end
    // remember which fetch byte was requested; its data returns next cycle
    if (ctl.mem_en && ctl.asel == AS_FETCH) fidx_r <= ctl.fbyte;
    if (ctl.fetch_cap) begin
      case (fidx_r)
        3'd0: op_r <= rdata;
        3'd1: a0_r[15:8] <= rdata;
        3'd2: a0_r[7:0] <= rdata;
        3'd3: a1_r[15:8] <= rdata;
        default: a1_r[7:0] <= rdata;
      endcase
    end
    if (ctl.decode) begin
      ea_r <= ea_nxt; sv_r <= sv_nxt;
    end
    if (ctl.cap_hi) dhi_r <= rdata;
    if (ctl.cap_lo) dlo_r <= rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ra_r <= '0; rb_r <= '0; rc_r <= '0; rd_r <= '0;
      sp_r <= '0; ip_r <= '0; ix_r <= '0; iy_r <= '0; fl_r <= '0;
    end else if (ctl.exec) begin
      ra_r <= ra_n; rb_r <= rb_n; rc_r <= rc_n; rd_r <= rd_n;
      sp_r <= sp_n; ip_r <= ip_n; ix_r <= ix_n; iy_r <= iy_n; fl_r <= fl_n;
    end
  end

  // result registered in the controller's execute or finish step
  logic       run_q, flt_q;
  logic [7:0] rbyte_q;
  always_ff @(posedge clk) begin
    if (ctl.result) begin
      rbyte_q <= (cmd_r == CMD_READ) ? rdata : 8'd0;
      run_q   <= !(cmd_r == CMD_EXEC && !sts.fault && !run);
      flt_q   <= cmd_r == CMD_EXEC && sts.fault;
    end
  end

  assign res_read_byte = rbyte_q;
  assign res_running   = run_q;
  assign res_fault     = flt_q;
  assign res_pc        = ip_r;
  assign res_flags     = fl_r;
endmodule

>>> rtl/cic_ctrl.sv
// cic_ctrl: sequencer for host transactions and instruction steps.
// Depends on cic_pkg.
module cic_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  cic_pkg::sts_t sts,
  output cic_pkg::ctl_t ctl
);
  import cic_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_HOST  = 8'b0000_0010,  // host read/write or first fetch issued, wait data
    S_FETCH = 8'b0000_0100,
    S_DEC   = 8'b0000_1000,
    S_MEM   = 8'b0001_0000,
    S_EXEC  = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000   // result register loads
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       outv_r, outv_nxt;

  // accept only when idle and the output register is free
  assign in_stall  = !(state_r == S_IDLE) || outv_r;
  assign out_valid = outv_r;

  always_comb begin
    ctl = '0;
    ctl.asel = AS_HOST;
    ctl.wsel = WD_HOST;
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    outv_nxt = outv_r && out_stall;
    unique case (state_r)
      S_IDLE: if (in_valid && !in_stall) begin
        ctl.latch_cmd = 1'b1;
        state_nxt = S_HOST;
      end
      S_HOST: begin
        if (sts.is_exec) begin
          ctl.mem_en = 1'b1; ctl.asel = AS_FETCH; ctl.fbyte = 3'd0;
          cnt_nxt = 3'd1; state_nxt = S_FETCH;
        end else begin
          ctl.mem_en = sts.is_write || sts.is_read;
          ctl.mem_we = sts.is_write;
          state_nxt = S_FIN;
        end
      end
      S_FETCH: begin
        // capture the byte requested last cycle, request the next one if any
        ctl.fetch_cap = 1'b1;
        if (cnt_r == 3'(INSN_BYTES)) begin
          state_nxt = S_DEC;
        end else begin
          ctl.mem_en = 1'b1; ctl.asel = AS_FETCH; ctl.fbyte = cnt_r;
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_DEC: begin
        ctl.decode = 1'b1; cnt_nxt = '0;
        state_nxt = (!sts.fault && (sts.nrd || sts.nwr)) ? S_MEM : S_EXEC;
      end
      S_MEM: begin
        // step 0: first access; step 1: second access / capture first;
        // step 2: capture second
        cnt_nxt = cnt_r + 3'd1;
        if (sts.nwr) begin
          ctl.mem_en = 1'b1; ctl.mem_we = 1'b1;
          if (cnt_r == 3'd0) begin
            ctl.asel = sts.wr_stack ? AS_SP : AS_EA;
            ctl.wsel = sts.wr_two ? WD_HI : WD_LO;
            if (!sts.wr_two) state_nxt = S_EXEC;
          end else begin
            ctl.asel = sts.wr_stack ? AS_SPM1 : AS_EA1;
            ctl.wsel = WD_LO;
            state_nxt = S_EXEC;
          end
        end else begin
          if (cnt_r == 3'd0) begin
            ctl.mem_en = 1'b1;
            ctl.asel = sts.rd_stack ? (sts.rd_two ? AS_SPP2 : AS_SPP1) : AS_EA;
          end else if (cnt_r == 3'd1) begin
            if (sts.rd_two) begin
              ctl.mem_en = 1'b1;
              ctl.asel = sts.rd_stack ? AS_SPP1 : AS_EA1;
              ctl.cap_hi = 1'b1;
            end else begin
              ctl.cap_lo = 1'b1; state_nxt = S_EXEC;
            end
          end else begin
            ctl.cap_lo = 1'b1; state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        ctl.result = 1'b1;
        ctl.exec = !sts.fault;
        state_nxt = S_OUT;
      end
      S_FIN: begin
        ctl.result = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        outv_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; outv_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; outv_r <= outv_nxt;
    end
  end
endmodule

>>> rtl/custom_isa_cpu_core_top.sv
// custom_isa_cpu_core_top: a small CPU core with a byte-wide main memory.
// Host channel in_*: one transaction is a memory write (opcode 0), a memory
// read (1), one execute step (2) or a no-op (3). Result channel out_*: one
// transaction per accepted input, carrying read data, running, fault,
// program counter and flags after the command.
// Write, read and no-op: host access, result load, output. An execute step:
// host step, fetch of each instruction byte, decode, the memory steps of a
// data access of one or two bytes if any, execute, output; the one RAM port
// is the limit, one byte per cycle. Throughput: one transaction at a time,
// the next accepted the cycle after the result leaves.
// in_stall is high while a transaction is in flight or a result is waiting.
// When the receiver stalls, out_valid and the out_* fields hold steady.
// Reset (rst_n low, synchronous) clears registers, flags, stack and
// instruction pointers; main memory is not cleared and reads of never
// written bytes return unspecified data.
// Depends on cic_pkg, cic_ram, cic_datapath, cic_ctrl.
module custom_isa_cpu_core_top #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_byte,
  output logic        out_running,
  output logic        out_fault,
  output logic [15:0] out_program_counter,
  output logic [2:0]  out_status_flags
);
  import cic_pkg::*;

  ctl_t ctl;
  sts_t sts;

  cic_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .ctl(ctl)
  );

  cic_datapath #(.ADDR_BITS(ADDR_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_opcode(in_opcode), .in_address(in_address),
    .in_write_byte(in_write_byte),
    .res_read_byte(out_read_byte), .res_running(out_running),
    .res_fault(out_fault), .res_pc(out_program_counter),
    .res_flags(out_status_flags)
  );
endmodule

>>> rtl/cic_checker.sv
// cic_checker: port-level assertions for the CPU core top level.
// Depends on custom_isa_cpu_core_top (bound below).
module cic_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_program_counter
);
  // no new transaction while a result waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accept with result pending");

  // a result never appears right after an accept
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");

  // held result keeps the program counter
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_program_counter)))
    else $error("stalled result changed");

  // out of reset nothing is pending
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("valid after reset");
endmodule

bind custom_isa_cpu_core_top cic_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_program_counter(out_program_counter)
);

>>> tb/tb_top.sv
// tb_top: self-checking testbench for custom_isa_cpu_core_top.
// Depends on cic_pkg and the RTL of the core. The stimulus generator runs a
// cycle-free copy of the core and queues the expected outcome of each command.
`timescale 1ns / 1ps

module tb_top;
  import cic_pkg::*;

  localparam int unsigned NUM_XACTS = 650;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 30;

  // one host transaction; hold makes the driver wait until all results are back
  typedef struct {
    cmd_t        cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    bit          hold;
  } host_xact_t;

  // what the core reports after one transaction
  typedef struct {
    logic [7:0]  rbyte;
    logic        run;
    logic        flt;
    logic [15:0] pc;
    logic [2:0]  flags;
  } core_status_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = 2'd0;
  logic [15:0] in_address = 16'd0;
  logic [7:0]  in_write_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_byte;
  logic        out_running;
  logic        out_fault;
  logic [15:0] out_program_counter;
  logic [2:0]  out_status_flags;

  custom_isa_cpu_core_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_address          (in_address),
    .in_write_byte       (in_write_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_byte       (out_read_byte),
    .out_running         (out_running),
    .out_fault           (out_fault),
    .out_program_counter (out_program_counter),
    .out_status_flags    (out_status_flags)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the core's architectural state
  // ---------------------------------------------------------------------------
  logic [7:0]  shadow_mem [65536];
  bit          mem_written [65536];
  logic [15:0] ra, rb, rc, rdd, sp, ip;
  logic [7:0]  ix, iy;
  logic [2:0]  fl;

  host_xact_t   pending_xacts [$];
  core_status_t expected_status [$];
  int unsigned  n_gen, n_exec, n_fault, n_halt, n_acc, n_recv, n_errors, n_cycles;
  bit           burst_mode;

  function automatic logic [7:0] g8(input logic [15:0] i);
    case (i)
      16'd0: return ra[7:0];
      16'd1: return ra[15:8];
      16'd2: return rb[7:0];
      16'd3: return rb[15:8];
      16'd4: return rc[7:0];
      16'd5: return rc[15:8];
      16'd6: return rdd[7:0];
      16'd7: return rdd[15:8];
      16'd8: return ix;
      16'd9: return iy;
      default: return 8'd0;
    endcase
  endfunction

  function automatic void s8(input logic [15:0] i, input logic [7:0] v);
    case (i)
      16'd0: ra[7:0] = v;
      16'd1: ra[15:8] = v;
      16'd2: rb[7:0] = v;
      16'd3: rb[15:8] = v;
      16'd4: rc[7:0] = v;
      16'd5: rc[15:8] = v;
      16'd6: rdd[7:0] = v;
      16'd7: rdd[15:8] = v;
      16'd8: ix = v;
      16'd9: iy = v;
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] g16(input logic [15:0] i);
    case (i)
      16'd0: return ra;
      16'd1: return rb;
      16'd2: return rc;
      16'd3: return rdd;
      16'd4: return sp;
      16'd5: return ip;
      default: return 16'd0;
    endcase
  endfunction

  function automatic void s16(input logic [15:0] i, input logic [15:0] v);
    case (i)
      16'd0: ra = v;
      16'd1: rb = v;
      16'd2: rc = v;
      16'd3: rdd = v;
      16'd4: sp = v;
      16'd5: ip = v;
      default: ;
    endcase
  endfunction

  function automatic void mem_wr(input logic [15:0] a, input logic [7:0] v);
    shadow_mem[a] = v;
    mem_written[a] = 1'b1;
  endfunction

  function automatic logic [15:0] word_at(input logic [15:0] a);
    logic [15:0] a1;
    a1 = a + 16'd1;
    return {shadow_mem[a], shadow_mem[a1]};
  endfunction

  // add with carry in from the flags; carry out goes back
  function automatic logic [15:0] add_carry(input logic [15:0] x, input logic [15:0] y,
                                            input bit wide);
    logic [16:0] s;
    s = {1'b0, x} + {1'b0, y} + {16'd0, fl[0]};
    fl[0] = wide ? s[16] : s[8];
    return wide ? s[15:0] : {8'd0, s[7:0]};
  endfunction

  function automatic void to_acc(input logic [15:0] v);
    ra = v;
    fl[1] = (v == 16'd0);
  endfunction

  function automatic void compare_vals(input logic [15:0] x, input logic [15:0] y);
    fl[1] = (x == y);
    fl[2] = (x < y);
  endfunction

  // one instruction; returns {running, fault}
  function automatic logic [1:0] exec_insn();
    logic [7:0]  op, b1, v8;
    logic [15:0] a0, a1, w, ad, ipn;
    bit          z, l, ok, jmp;
    logic        run;
    op = shadow_mem[ip];
    a0 = word_at(ip + 16'd1);
    ipn = ip + 16'd3;
    a1 = word_at(ipn);
    b1 = a1[7:0];
    z = fl[1];
    l = fl[2];
    ok = 1'b1;
    jmp = 1'b0;
    run = 1'b1;
    case (op)
      OP_ADD, OP_MOV, OP_CMP, OP_AND, OP_OR, OP_XOR:
        ok = (a0 < 10) && (a1 < 10);
      OP_ADDW, OP_MOVW, OP_LDFAW, OP_STAW, OP_CMPW, OP_ANDW, OP_ORW, OP_XORW:
        ok = (a0 < 6) && (a1 < 6);
      OP_ADDI, OP_PUSH, OP_POP, OP_LDI, OP_LDFAI, OP_CMPI, OP_ANDI, OP_ORI,
      OP_INV, OP_XORI, OP_REGADD:
        ok = (a0 < 10);
      OP_ADDIW, OP_JMP, OP_PUSHW, OP_POPW, OP_LDIW, OP_LDFAIW, OP_STAI, OP_STAIW,
      OP_CMPIW, OP_ANDIW, OP_ORIW, OP_INVW, OP_XORIW, OP_REGADDW:
        ok = (a0 < 6);
      OP_JEQ: ok = !z || (a0 < 6);
      OP_JNE: ok = z || (a0 < 6);
      OP_JLT: ok = !l || (a0 < 6);
      OP_JGT: ok = l || (a0 < 6);
      OP_LDFA: ok = (a0 < 10) && (a1 < 6);
      OP_STA: ok = (a0 < 6) && (a1 < 10);
      default: ;
    endcase
    if (!ok) return 2'b11;

    case (op)
      OP_ADD:   to_acc(add_carry({8'd0, g8(a0)}, {8'd0, g8(a1)}, 1'b0));
      OP_ADDW:  to_acc(add_carry(g16(a0), g16(a1), 1'b1));
      OP_ADDI:  to_acc(add_carry({8'd0, g8(a0)}, {8'd0, b1}, 1'b0));
      OP_ADDIW: to_acc(add_carry(g16(a0), a1, 1'b1));
      OP_JMP:   begin ip = g16(a0); jmp = 1'b1; end
      OP_JMPI:  begin ip = a0; jmp = 1'b1; end
      OP_JEQ, OP_JEQI:
        if (z) begin
          ip = (op == OP_JEQ) ? g16(a0) : a0;
          jmp = 1'b1;
          fl[1] = 1'b0;
        end
      OP_JNE, OP_JNEI:
        if (!z) begin
          ip = (op == OP_JNE) ? g16(a0) : a0;
          jmp = 1'b1;
        end
      OP_JLT, OP_JLTI:
        if (l) begin
          ip = (op == OP_JLT) ? g16(a0) : a0;
          jmp = 1'b1;
          fl[2] = 1'b0;
        end
      OP_JGT, OP_JGTI:
        if (!l) begin
          ip = (op == OP_JGT) ? g16(a0) : a0;
          jmp = 1'b1;
        end
      OP_PUSH: begin mem_wr(sp, g8(a0)); sp = sp - 16'd1; end
      OP_PUSHW: begin
        w = g16(a0);
        mem_wr(sp, w[15:8]);
        mem_wr(sp - 16'd1, w[7:0]);
        sp = sp - 16'd2;
      end
      OP_POP: begin sp = sp + 16'd1; s8(a0, shadow_mem[sp]); end
      OP_POPW: begin
        sp = sp + 16'd2;
        ad = sp - 16'd1;
        s16(a0, {shadow_mem[sp], shadow_mem[ad]});
      end
      OP_MOV:    s8(a0, g8(a1));
      OP_MOVW:   s16(a0, g16(a1));
      OP_LDI:    s8(a0, b1);
      OP_LDIW:   s16(a0, a1);
      OP_LDFA:   s8(a0, shadow_mem[g16(a1)]);
      OP_LDFAW:  s16(a0, word_at(g16(a1)));
      OP_LDFAI:  s8(a0, shadow_mem[a1]);
      OP_LDFAIW: s16(a0, word_at(a1));
      OP_STA:    mem_wr(g16(a0), g8(a1));
      OP_STAW: begin
        ad = g16(a0);
        w = g16(a1);
        mem_wr(ad, w[15:8]);
        mem_wr(ad + 16'd1, w[7:0]);
      end
      OP_STAI:   mem_wr(g16(a0), b1);
      OP_STAIW: begin
        ad = g16(a0);
        mem_wr(ad, a1[15:8]);
        mem_wr(ad + 16'd1, a1[7:0]);
      end
      OP_CMP:    compare_vals({8'd0, g8(a0)}, {8'd0, g8(a1)});
      OP_CMPW:   compare_vals(g16(a0), g16(a1));
      OP_CMPI:   compare_vals({8'd0, g8(a0)}, {8'd0, b1});
      OP_CMPIW:  compare_vals(g16(a0), a1);
      OP_HLT:    run = 1'b0;
      OP_AND:    to_acc({8'd0, g8(a0) & g8(a1)});
      OP_ANDW:   to_acc(g16(a0) & g16(a1));
      OP_ANDI:   to_acc({8'd0, g8(a0) & b1});
      OP_ANDIW:  to_acc(g16(a0) & a1);
      OP_OR:     to_acc({8'd0, g8(a0) | g8(a1)});
      OP_ORW:    to_acc(g16(a0) | g16(a1));
      OP_ORI:    to_acc({8'd0, g8(a0) | b1});
      OP_ORIW:   to_acc(g16(a0) | a1);
      OP_INV:    to_acc({8'd0, ~g8(a0)});
      OP_INVW:   to_acc(~g16(a0));
      OP_XOR:    to_acc({8'd0, g8(a0) ^ g8(a1)});
      OP_XORW:   to_acc(g16(a0) ^ g16(a1));
      OP_XORI:   to_acc({8'd0, g8(a0) ^ b1});
      OP_XORIW:  to_acc(g16(a0) ^ a1);
      OP_REGADD: begin v8 = g8(a0) + b1; s8(a0, v8); end
      OP_REGADDW: s16(a0, g16(a0) + a1);
      OP_INY:    iy = iy + 8'd1;
      OP_INX:    ix = ix + 8'd1;
      default: ;
    endcase
    if (!jmp) ip = ip + 16'd5;
    return {run, 1'b0};
  endfunction

  // queue a transaction and the status the core must report for it
  function automatic void send(input cmd_t c, input logic [15:0] a, input logic [7:0] d,
                               input bit hold = 1'b0);
    host_xact_t   x;
    core_status_t s;
    logic [1:0]   rf;
    x = '{cmd: c, addr: a, data: d, hold: hold};
    pending_xacts.push_back(x);
    n_gen++;
    s.rbyte = 8'd0;
    s.run = 1'b1;
    s.flt = 1'b0;
    case (c)
      CMD_WRITE: mem_wr(a, d);
      CMD_READ:  s.rbyte = shadow_mem[a];
      CMD_EXEC: begin
        rf = exec_insn();
        s.run = rf[1];
        s.flt = rf[0];
        n_exec++;
        if (rf[0]) n_fault++;
        if (!rf[1]) n_halt++;
      end
      default: ;
    endcase
    s.pc = ip;
    s.flags = fl;
    expected_status.push_back(s);
  endfunction

  // never-written bytes must not be read: fill them first
  function automatic void fill_if_blank(input logic [15:0] a);
    if (!mem_written[a]) send(CMD_WRITE, a, 8'($urandom));
  endfunction

  // run one step; a fresh instruction is stored at ip unless old code is reused
  function automatic void step(input bit fresh, input logic [7:0] op,
                               input logic [15:0] a0, input logic [15:0] a1);
    bit          code_ok;
    logic [15:0] ea;
    code_ok = 1'b1;
    for (int k = 0; k < 5; k++) if (!mem_written[16'(ip + k)]) code_ok = 1'b0;
    if (!fresh && code_ok) begin
      op = shadow_mem[ip];
      a1 = word_at(ip + 16'd3);
    end else begin
      fresh = 1'b1;
    end
    case (op)
      OP_POP: fill_if_blank(sp + 16'd1);
      OP_POPW: begin fill_if_blank(sp + 16'd1); fill_if_blank(sp + 16'd2); end
      OP_LDFA: fill_if_blank(g16(a1));
      OP_LDFAW: begin ea = g16(a1); fill_if_blank(ea); fill_if_blank(ea + 16'd1); end
      OP_LDFAI: fill_if_blank(a1);
      OP_LDFAIW: begin fill_if_blank(a1); fill_if_blank(a1 + 16'd1); end
      default: ;
    endcase
    if (fresh) begin
      send(CMD_WRITE, ip, op);
      send(CMD_WRITE, ip + 16'd1, a0[15:8]);
      send(CMD_WRITE, ip + 16'd2, a0[7:0]);
      send(CMD_WRITE, ip + 16'd3, a1[15:8]);
      send(CMD_WRITE, ip + 16'd4, a1[7:0]);
    end
    send(CMD_EXEC, 16'($urandom), 8'($urandom));
  endfunction

  function automatic logic [15:0] rand_arg(input int pct_small);
    if ($urandom_range(99) < pct_small) return 16'($urandom_range(10));
    return 16'($urandom);
  endfunction

  // mostly short idles, a few long ones, none at all in burst stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feeds pending transactions, honoring in_stall and random gaps
  // ---------------------------------------------------------------------------
  int unsigned drv_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap <= 0;
    end else begin
      if (in_valid && !in_stall) n_acc <= n_acc + 1;
      // slot frees when nothing is presented or the current one is taken
      if (!in_valid || !in_stall) begin
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_xacts.size() > 0 &&
                     (!pending_xacts[0].hold || (!in_valid && n_recv == n_acc))) begin
          in_opcode <= pending_xacts[0].cmd;
          in_address <= pending_xacts[0].addr;
          in_write_byte <= pending_xacts[0].data;
          in_valid <= 1'b1;
          pending_xacts.pop_front();
          drv_gap <= pick_gap();
          if ($urandom_range(99) < 2) burst_mode <= !burst_mode;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure and in-order compare of each result
  // ---------------------------------------------------------------------------
  int unsigned mon_stall;

  always @(posedge clk) begin
    core_status_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      mon_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_recv <= n_recv + 1;
        if (expected_status.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("ERROR: unexpected result transaction at cycle %0d",
                                       n_cycles);
        end else begin
          e = expected_status.pop_front();
          if (out_read_byte !== e.rbyte || out_running !== e.run || out_fault !== e.flt ||
              out_program_counter !== e.pc || out_status_flags !== e.flags) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: result %0d exp rd=%h run=%b flt=%b pc=%h fl=%b got rd=%h run=%b flt=%b pc=%h fl=%b",
                       n_recv, e.rbyte, e.run, e.flt, e.pc, e.flags, out_read_byte,
                       out_running, out_fault, out_program_counter, out_status_flags);
          end
        end
      end
      if (mon_stall > 0) begin
        out_stall <= 1'b1;
        mon_stall <= mon_stall - 1;
      end else begin
        out_stall <= 1'b0;
        mon_stall <= pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("custom_isa_cpu_core_top verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned r, total;
    bit          held;
    ra = 0; rb = 0; rc = 0; rdd = 0; sp = 0; ip = 0; ix = 0; iy = 0; fl = 0;
    n_gen = 0; n_exec = 0; n_fault = 0; n_halt = 0;
    n_acc = 0; n_recv = 0; n_errors = 0; n_cycles = 0;
    burst_mode = 1'b0;
    held = 1'b0;

    // directed: address extremes, no-op, carry, compare/jump, halt, fault, bad opcode
    send(CMD_WRITE, 16'hffff, 8'hff);
    send(CMD_WRITE, 16'h0000, 8'h00);
    send(CMD_READ, 16'hffff, 8'h00);
    send(CMD_READ, 16'h0000, 8'hff);
    send(CMD_NOP, 16'hffff, 8'hff);
    step(1'b1, OP_LDIW, 16'd0, 16'hffff);
    step(1'b1, OP_ADDIW, 16'd0, 16'h0001);      // wraps to zero with carry out
    step(1'b1, OP_CMPIW, 16'd0, 16'h0000);      // equal sets zero flag
    step(1'b1, OP_JEQI, 16'h0100, 16'h0000);    // taken, clears zero flag
    step(1'b1, OP_CMPI, 16'd0, 16'h0001);       // less-than
    step(1'b1, OP_JLTI, 16'hfffe, 16'h0000);    // taken near top of memory
    step(1'b1, OP_POPW, 16'd1, 16'd0);          // pop with the stack pointer at zero
    step(1'b1, OP_MOV, 16'd10, 16'd0);          // unknown register index
    step(1'b1, 8'hff, 16'hffff, 16'hffff);      // undefined opcode
    step(1'b1, OP_LDIW, 16'd5, 16'h1000);       // write into instr pointer
    step(1'b1, OP_HLT, 16'd0, 16'd0);
    send(CMD_READ, 16'hffff, 8'h00, 1'b1);      // wait for full drain first

    // random: mostly well-formed programs built as they run
    while (n_gen < NUM_XACTS) begin
      r = $urandom_range(99);
      if (r < 12) begin
        send(CMD_WRITE, 16'($urandom), 8'($urandom));
      end else if (r < 22) begin
        total = $urandom_range(5);
        fill_if_blank(ip + 16'(total));
        send(CMD_READ, ip + 16'(total), 8'($urandom), !held && n_gen > NUM_XACTS / 2);
        if (n_gen > NUM_XACTS / 2) held = 1'b1;
      end else if (r < 25) begin
        send(CMD_NOP, 16'($urandom), 8'($urandom));
      end else begin
        r = $urandom_range(99);
        step($urandom_range(99) < 45,
             (r < 90) ? 8'($urandom_range(52)) : 8'($urandom_range(53, 255)),
             rand_arg(80), rand_arg(50));
      end
    end
    total = n_gen;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_xacts.size() == 0 && n_recv == total);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d transactions: %0d execute steps (%0d faults, %0d halts),",
             total, n_exec, n_fault, n_halt);
    $display("with random gaps and back-pressure; %0d mismatches in %0d cycles.",
             n_errors, n_cycles);
    if (n_errors == 0 && expected_status.size() == 0) begin
      $display("custom_isa_cpu_core_top verification clean");
    end else begin
      $display("custom_isa_cpu_core_top verification failed");
    end
    $finish;
  end

endmodule
